// ===== sv/alrs_pkg.sv =====
`default_nettype none
package alrs_pkg;

    // field widths
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int MS_W     = 32;
    localparam int SECS_W   = 12;
    localparam int LEVEL_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // seconds * 1000 fits in 22 bits for a 12-bit seconds value
    localparam int MS_PER_SEC   = 1000;
    localparam int MSEC_W       = 10;
    localparam int DIVISOR_W    = SECS_W + MSEC_W;
    // dividend is elapsed * 256
    localparam int DIVIDEND_W   = MS_W + LEVEL_W;
    localparam int DIV_STEPS    = DIVIDEND_W;
    localparam int CNT_W        = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_OFF  = '0;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_STOP = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_HOUR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_MINUTE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_SECONDS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SECONDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_SECONDS = 3'd5;

    typedef enum logic [2:0] {
        PH_WAIT_ALARM  = 3'd0,
        PH_RISE        = 3'd1,
        PH_HOLD        = 3'd2,
        PH_FALL        = 3'd3,
        PH_WAIT_MINUTE = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DIV    = 2'd1,
        S_COMMIT = 2'd2
    } t_ctrl_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic out_busy;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== sv/alrs_ctrl.sv =====
`default_nettype none
module alrs_ctrl
    import alrs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_ctrl_state      r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                n_count = '0;
                if (i_in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_status.need_div || r_count == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_COMMIT;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_COMMIT: begin
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV: begin
                o_cmd.div_step = i_status.need_div;
            end
            S_COMMIT: begin
                o_cmd.commit = !i_status.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DIV && r_count == '0))
        else $error("load did not start a fresh division");

    a_skip_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_status.need_div) |=> r_state == S_COMMIT)
        else $error("non-ramp item did not go straight to commit");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_count < CNT_W'(DIV_STEPS))
        else $error("division step count out of range");
`endif

endmodule
`default_nettype wire

// ===== sv/alrs_datapath.sv =====
`default_nettype none
module alrs_datapath
    import alrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_operation,
    input  wire logic [HOUR_W-1:0]     i_clock_hour,
    input  wire logic [MINUTE_W-1:0]   i_clock_minute,
    input  wire logic [MS_W-1:0]       i_now_ms,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [LEVEL_W-1:0]         o_brightness
);

    // configuration
    logic [HOUR_W-1:0]   r_wake_hour;
    logic [MINUTE_W-1:0] r_wake_minute;
    logic                r_alarm_enable;
    logic [SECS_W-1:0]   r_rise_seconds;
    logic [SECS_W-1:0]   r_hold_seconds;
    logic [SECS_W-1:0]   r_fall_seconds;

    // sequencer state
    t_phase              r_phase, n_phase;
    logic [MS_W-1:0]     r_phase_start, n_phase_start;

    // captured item
    logic                r_op;
    logic [HOUR_W-1:0]   r_hour;
    logic [MINUTE_W-1:0] r_minute;
    logic [MS_W-1:0]     r_now;
    logic [MS_W-1:0]     r_elapsed;

    // divider
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [DIVISOR_W-1:0]  r_divisor;
    logic [DIVISOR_W-1:0]  r_hold_lim;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [LEVEL_W-1:0]    r_quot;
    logic                  r_sat;
    logic [DIVISOR_W:0]    rem_sh;
    logic                  rem_ge;

    // output
    logic                r_out_valid;
    logic [LEVEL_W-1:0]  r_brightness;

    logic [MS_W-1:0]     elapsed_now;
    logic [SECS_W-1:0]   ramp_secs;
    logic [LEVEL_W-1:0]  ratio;
    logic                ratio_full;
    logic                time_match;
    logic [LEVEL_W-1:0]  n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_hour    <= HOUR_W'(7);
            r_wake_minute  <= '0;
            r_alarm_enable <= 1'b0;
            r_rise_seconds <= SECS_W'(1800);
            r_hold_seconds <= SECS_W'(600);
            r_fall_seconds <= SECS_W'(60);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WAKE_HOUR:    r_wake_hour    <= i_cfg_data[HOUR_W-1:0];
                REG_WAKE_MINUTE:  r_wake_minute  <= i_cfg_data[MINUTE_W-1:0];
                REG_ALARM_ENABLE: r_alarm_enable <= i_cfg_data[0];
                REG_RISE_SECONDS: r_rise_seconds <= i_cfg_data[SECS_W-1:0];
                REG_HOLD_SECONDS: r_hold_seconds <= i_cfg_data[SECS_W-1:0];
                REG_FALL_SECONDS: r_fall_seconds <= i_cfg_data[SECS_W-1:0];
                default: ;
            endcase
        end
    end

    assign elapsed_now = i_now_ms - r_phase_start;
    assign ramp_secs   = (r_phase == PH_FALL) ? r_fall_seconds : r_rise_seconds;

    // restoring divide, one quotient bit a step
    assign rem_sh = {r_rem, r_dvd[DIVIDEND_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_operation;
            r_hour     <= i_clock_hour;
            r_minute   <= i_clock_minute;
            r_now      <= i_now_ms;
            r_elapsed  <= elapsed_now;
            r_dvd      <= {elapsed_now, LEVEL_W'(0)};
            r_divisor  <= DIVISOR_W'(ramp_secs) * DIVISOR_W'(MS_PER_SEC);
            r_hold_lim <= DIVISOR_W'(r_hold_seconds) * DIVISOR_W'(MS_PER_SEC);
            r_rem      <= '0;
            r_quot     <= '0;
            r_sat      <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[DIVIDEND_W-2:0], 1'b0};
            r_rem  <= rem_ge ? DIVISOR_W'(rem_sh - {1'b0, r_divisor})
                             : rem_sh[DIVISOR_W-1:0];
            r_quot <= {r_quot[LEVEL_W-2:0], rem_ge};
            r_sat  <= r_sat | r_quot[LEVEL_W-1];
        end
    end

    // zero duration gives an all-ones quotient, so it saturates at once
    assign ratio      = (r_sat || r_quot == LEVEL_FULL) ? LEVEL_FULL : r_quot;
    assign ratio_full = ratio == LEVEL_FULL;
    assign time_match = (r_hour == r_wake_hour) && (r_minute == r_wake_minute);

    always_comb begin
        n_phase       = r_phase;
        n_phase_start = r_phase_start;
        n_level       = LEVEL_OFF;
        if (r_op == OP_STOP) begin
            n_phase = PH_WAIT_MINUTE;
        end else begin
            case (r_phase)
                PH_RISE: begin
                    n_level = ratio;
                    if (ratio_full) begin
                        n_phase       = PH_HOLD;
                        n_phase_start = r_now;
                    end
                end
                PH_HOLD: begin
                    n_level = LEVEL_FULL;
                    if (r_elapsed > MS_W'(r_hold_lim)) begin
                        n_phase       = PH_FALL;
                        n_phase_start = r_now;
                    end
                end
                PH_FALL: begin
                    n_level = LEVEL_FULL - ratio;
                    if (ratio_full) begin
                        n_phase       = PH_WAIT_MINUTE;
                        n_phase_start = r_now;
                    end
                end
                PH_WAIT_MINUTE: begin
                    if (!time_match) begin
                        n_phase = PH_WAIT_ALARM;
                    end
                end
                default: begin
                    if (time_match && r_alarm_enable) begin
                        n_phase       = PH_RISE;
                        n_phase_start = r_now;
                    end else begin
                        n_phase = PH_WAIT_ALARM;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_WAIT_ALARM;
            r_phase_start <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_phase       <= n_phase;
                r_phase_start <= n_phase_start;
            end
            if (i_cmd.commit && r_op == OP_TICK) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_op == OP_TICK) begin
            r_brightness <= n_level;
        end
    end

    assign o_status.need_div = (r_op == OP_TICK) && (r_phase == PH_RISE || r_phase == PH_FALL);
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_brightness      = r_brightness;

`ifndef SYNTHESIS
    a_tick_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == OP_TICK) |=> o_out_valid)
        else $error("tick commit gave no item");

    a_stop_to_minute_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == OP_STOP) |=> r_phase == PH_WAIT_MINUTE)
        else $error("stop did not move to minute wait");

    a_hold_exits_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == OP_TICK && r_phase == PH_HOLD)
            |=> (r_phase == PH_HOLD || r_phase == PH_FALL))
        else $error("hold phase left to an unexpected phase");
`endif

endmodule
`default_nettype wire

// ===== sv/alarm_light_ramp_sequencer_core.sv =====
`default_nettype none
// alarm light ramp sequencer: each tick item (hour, minute, millisecond
// timestamp) yields one brightness item 0..255, a stop item yields none and
// sends the sequencer to the minute-change wait. phases run wait for alarm,
// ramp up, hold at full, ramp down, wait for the minute to change. the ramp
// level is elapsed_ms * 256 / (seconds * 1000), saturated at 255, worked out
// by a bit-serial restoring divider that retires one quotient bit a cycle
// over the 40-bit dividend. a ramp tick runs through load, 40 divide steps
// and commit; a tick in any other phase and a stop skip the divide steps.
// the commit cycle stretches for as long as the output register still holds
// a result that has not been taken. one item is in work at a time; the next
// item is accepted as soon as the previous one is committed, even while its
// result still sits in the output register. configuration writes take effect
// at once and are meant for idle periods only.
module alarm_light_ramp_sequencer_core
    import alrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_operation,
    input  wire logic [HOUR_W-1:0]     i_clock_hour,
    input  wire logic [MINUTE_W-1:0]   i_clock_minute,
    input  wire logic [MS_W-1:0]       i_now_ms,
    // result items
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [LEVEL_W-1:0]         o_brightness
);

    // command and status between sequencing control and datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // controller: load, divide steps, commit (waits for a free output register)
    alrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // datapath: config registers, phase state, divider, output register
    alrs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_clock_hour   (i_clock_hour),
        .i_clock_minute (i_clock_minute),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_brightness   (o_brightness)
    );

endmodule
`default_nettype wire
